### hdl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Types and codes shared by the double-ended queue controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_READ_AT    = 3'd2;
    localparam logic [2:0] CMD_WRITE_AT   = 3'd3;
    localparam logic [2:0] CMD_READ_FRONT = 3'd4;
    localparam logic [2:0] CMD_READ_BACK  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_ctrl;

endpackage

`default_nettype wire

### hdl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: capture an item, run it against the ring store, hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_ready,
    output deq_pkg::t_dp_ctrl      o_ctrl,
    output logic                   o_in_ready,
    output logic                   o_out_valid
);

    deq_pkg::t_state r_state;
    deq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            deq_pkg::S_IDLE: begin
                if (i_in_valid) n_state = deq_pkg::S_EXEC;
            end
            deq_pkg::S_EXEC: begin
                n_state = deq_pkg::S_RESP;
            end
            deq_pkg::S_RESP: begin
                if (i_out_ready) n_state = deq_pkg::S_IDLE;
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_ctrl      = '0;
        case (r_state)
            deq_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_valid;
            end
            deq_pkg::S_EXEC: begin
                o_ctrl.exec = 1'b1;
            end
            deq_pkg::S_RESP: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/deq_datapath.sv
// ----------------------------------------------------------------------------
// deq_datapath
// Ring store with head pointer and element count, command decode and result.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_datapath #(
    parameter int CAPACITY   = 256,
    parameter int ITEM_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire deq_pkg::t_dp_ctrl i_ctrl,
    input  wire logic [2:0]        i_command,
    input  wire logic [7:0]        i_position,
    input  wire logic [31:0]       i_value,
    output logic [31:0]            o_data,
    output logic [1:0]             o_status,
    output logic [8:0]             o_occupancy,
    output logic                   o_is_empty
);

    localparam int SW = (ITEM_WIDTH < 32) ? ITEM_WIDTH : 32;
    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int OW = (CW > 8) ? CW : 8;

    logic [SW-1:0] r_mem [CAPACITY];

    logic [2:0]    r_cmd;
    logic [7:0]    r_pos;
    logic [SW-1:0] r_val;
    logic [PW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_rd_data;
    logic          r_rd_sel;
    logic [1:0]    r_status;

    logic [PW-1:0] n_head;
    logic [CW-1:0] n_count;
    logic [1:0]    n_status;
    logic          we;
    logic          re;
    logic          full;
    logic          empty;
    logic          pos_bad;
    logic [CW-1:0] offset;
    logic [CW:0]   sum;
    logic [PW-1:0] slot;
    logic [PW-1:0] head_dec;
    logic [PW-1:0] addr;

    assign full     = (r_count == CW'(CAPACITY));
    assign empty    = (r_count == '0);
    assign pos_bad  = (OW'(r_pos) >= OW'(r_count));
    assign head_dec = (r_head == '0) ? PW'(CAPACITY - 1) : (r_head - PW'(1));

    always_comb begin
        sum = (CW + 1)'(r_head) + (CW + 1)'(offset);
        if (sum >= (CW + 1)'(CAPACITY)) begin
            sum = sum - (CW + 1)'(CAPACITY);
        end
        slot = sum[PW-1:0];
    end

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = deq_pkg::ST_OK;
        we       = 1'b0;
        re       = 1'b0;
        offset   = '0;
        addr     = slot;
        case (r_cmd)
            deq_pkg::CMD_PUSH_FRONT: begin
                addr = head_dec;
                if (full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    n_head  = head_dec;
                    n_count = r_count + CW'(1);
                    we      = 1'b1;
                end
            end
            deq_pkg::CMD_PUSH_BACK: begin
                offset = r_count;
                if (full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                    we      = 1'b1;
                end
            end
            deq_pkg::CMD_READ_AT: begin
                offset = CW'(r_pos);
                if (pos_bad) n_status = deq_pkg::ST_RANGE;
                else re = 1'b1;
            end
            deq_pkg::CMD_WRITE_AT: begin
                offset = CW'(r_pos);
                if (pos_bad) n_status = deq_pkg::ST_RANGE;
                else we = 1'b1;
            end
            deq_pkg::CMD_READ_FRONT: begin
                if (empty) n_status = deq_pkg::ST_RANGE;
                else re = 1'b1;
            end
            deq_pkg::CMD_READ_BACK: begin
                offset = r_count - CW'(1);
                if (empty) n_status = deq_pkg::ST_RANGE;
                else re = 1'b1;
            end
            default: begin
                n_status = deq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_ctrl.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_command;
            r_pos <= i_position;
            r_val <= SW'(i_value);
        end
        if (i_ctrl.exec) begin
            r_rd_sel <= re;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec && we) begin
            r_mem[addr] <= r_val;
        end
        if (i_ctrl.exec && re) begin
            r_rd_data <= r_mem[addr];
        end
    end

    assign o_data      = r_rd_sel ? 32'(r_rd_data) : 32'd0;
    assign o_status    = r_status;
    assign o_occupancy = 9'(r_count);
    assign o_is_empty  = empty;

endmodule

`default_nettype wire

### hdl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue on a ring store with head pointer and count.
// ----------------------------------------------------------------------------
// Each item is one command (push front or back, read or write at a position
// from the front, read front or back) and yields exactly one result item with
// the read data, a status code, the occupancy after the command and an empty
// flag. Each item passes in turn through the cycle in which it is accepted and
// captured, the single access to the ring store, whose read data is
// registered, and the cycle with the result presented. The next item is taken
// in the cycle after the result has been taken, so the queue cannot accept a
// new command before the result of the last one has been taken. No clearing
// pass follows reset.
`default_nettype none

module double_ended_queue #(
    parameter int CAPACITY   = 256,
    parameter int ITEM_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // position [7:0], value [39:8]
    input  wire logic [39:0] i_s_axis_tdata,
    // command [2:0]
    input  wire logic [2:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // data [31:0], occupancy [40:32], is_empty [41], zero [47:42]
    output logic [47:0]      o_m_axis_tdata,
    // status [1:0]
    output logic [1:0]       o_m_axis_tuser
);

    deq_pkg::t_dp_ctrl ctrl;
    logic [31:0]       data;
    logic [8:0]        occupancy;
    logic              is_empty;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_ctrl      (ctrl),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid)
    );

    deq_datapath #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_command   (i_s_axis_tuser),
        .i_position  (i_s_axis_tdata[7:0]),
        .i_value     (i_s_axis_tdata[39:8]),
        .o_data      (data),
        .o_status    (o_m_axis_tuser),
        .o_occupancy (occupancy),
        .o_is_empty  (is_empty)
    );

    assign o_m_axis_tdata = {6'd0, is_empty, occupancy, data};

endmodule

`default_nettype wire
